// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the speed loop controller RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define ESL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, masked while reset is high.
`define ESL_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- hw/rtl/esl_pkg.sv -----
// ---------------------------------------------------------------------------
// esl_pkg
// Types and fixed constants of the encoder speed loop controller.
// ---------------------------------------------------------------------------
package esl_pkg;

   localparam int SETPOINT_W = 16;
   localparam int CSR_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int DUTY_W     = 16;
   localparam int SPEED_W    = 16;
   localparam int ERROR_W    = 17;
   localparam int POS_W      = 32;
   localparam int SUM_W      = 24;
   localparam int INDEX_W    = 6;

   // shared multiplier and datapath widths
   localparam int MUL_A_W    = 34;
   localparam int MUL_B_W    = 32;
   localparam int PROD_W     = 56;
   localparam int PART_W     = 34;
   localparam int MIX_W      = 35;
   localparam int MAG_W      = 33;
   localparam int DIV_SHIFT  = 30;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam logic signed [SUM_W-1:0]   SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0]   SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
   localparam logic signed [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};
   localparam logic signed [ERROR_W-1:0] ERR_MAX   = {1'b0, {(ERROR_W-1){1'b1}}};
   localparam logic signed [ERROR_W-1:0] ERR_MIN   = {1'b1, {(ERROR_W-1){1'b0}}};

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KP_GAIN      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ALPHA = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_SCALE   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_RANGE   = 2'd3;

   localparam logic [CSR_W-1:0] KP_GAIN_RESET      = 16'd256;
   localparam logic [CSR_W-1:0] FILTER_ALPHA_RESET = 16'd32768;
   localparam logic [CSR_W-1:0] DUTY_SCALE_RESET   = 16'd256;
   localparam logic [CSR_W-1:0] DUTY_RANGE_RESET   = 16'd1024;

   typedef enum logic [1:0] {
      OP_ENC = 2'd0,
      OP_WIN = 2'd1,
      OP_CTL = 2'd2,
      OP_NOP = 2'd3
   } esl_op_type;

   typedef struct packed {
      esl_op_type                    op;
      logic                          enc_a;
      logic                          enc_b;
      logic signed [SETPOINT_W-1:0]  setpoint;
   } esl_cmd_type;

   typedef struct packed {
      logic        valid;
      esl_cmd_type cmd;
   } esl_slot_type;

endpackage

// ----- hw/rtl/esl_front.sv -----
// ---------------------------------------------------------------------------
// esl_front
// Input stage: take request beats, classify the operation, offer to queue.
// ---------------------------------------------------------------------------
module esl_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_operation,
   input  logic                                  req_enc_a,
   input  logic                                  req_enc_b,
   input  logic signed [esl_pkg::SETPOINT_W-1:0] req_setpoint,
   output esl_pkg::esl_slot_type                 push,
   input  logic                                  push_ready
);

   logic                 slot_valid_ff;
   esl_pkg::esl_cmd_type slot_cmd_ff;
   esl_pkg::esl_cmd_type slot_cmd_in;
   logic                 accept;

   assign req_stall = slot_valid_ff && !push_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      slot_cmd_in.op       = esl_pkg::esl_op_type'(req_operation);
      slot_cmd_in.enc_a    = req_enc_a;
      slot_cmd_in.enc_b    = req_enc_b;
      slot_cmd_in.setpoint = req_setpoint;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
      end else if (accept) begin
         slot_valid_ff <= 1'b1;
      end else if (push_ready) begin
         slot_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_cmd_ff <= slot_cmd_in;
      end
   end

   assign push.valid = slot_valid_ff;
   assign push.cmd   = slot_cmd_ff;

endmodule

// ----- hw/rtl/esl_queue.sv -----
// ---------------------------------------------------------------------------
// esl_queue
// Short command queue between front and back; each side stalls on its own.
// ---------------------------------------------------------------------------
module esl_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  esl_pkg::esl_slot_type push,
   output logic                  push_ready,
   output esl_pkg::esl_slot_type head,
   input  logic                  pop
);

   esl_pkg::esl_cmd_type              entry_ff [esl_pkg::QUEUE_DEPTH];
   logic [esl_pkg::QPTR_W-1:0]        wr_ptr_ff;
   logic [esl_pkg::QPTR_W-1:0]        rd_ptr_ff;
   logic [esl_pkg::QCNT_W-1:0]        count_ff;
   logic                              do_push;
   logic                              do_pop;

   assign push_ready = count_ff != esl_pkg::QCNT_W'(esl_pkg::QUEUE_DEPTH);
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop && (count_ff != '0);

   assign head.valid = count_ff != '0;
   assign head.cmd   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == esl_pkg::QPTR_W'(esl_pkg::QUEUE_DEPTH - 1)) ?
                         '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == esl_pkg::QPTR_W'(esl_pkg::QUEUE_DEPTH - 1)) ?
                         '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

// ----- hw/rtl/esl_back.sv -----
// ---------------------------------------------------------------------------
// esl_back
// Execution sequencer: position count, window average, error filter and
// drive stage around one shared multiplier; holds the result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module esl_back #(
   parameter int WINDOWS_PER_AVERAGE = 4,
   parameter int COUNT_WIDTH         = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  esl_pkg::esl_slot_type                head,
   output logic                                 pop,
   input  logic                                 csr_we,
   input  logic [esl_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [esl_pkg::CSR_W-1:0]            csr_wdata,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [esl_pkg::DUTY_W-1:0]           rsp_duty,
   output logic                                 rsp_direction,
   output logic signed [esl_pkg::SPEED_W-1:0]   rsp_measured_speed,
   output logic signed [esl_pkg::ERROR_W-1:0]   rsp_filtered_error,
   output logic signed [esl_pkg::POS_W-1:0]     rsp_position
);

   localparam int SUM_W = esl_pkg::SUM_W;
   localparam int DW    = (COUNT_WIDTH > SUM_W + 1) ? COUNT_WIDTH : SUM_W + 1;
   localparam logic [esl_pkg::DIV_SHIFT:0] RECIP =
      (esl_pkg::DIV_SHIFT + 1)'((64'd1 << esl_pkg::DIV_SHIFT) / WINDOWS_PER_AVERAGE);

   typedef enum logic [4:0] {
      S_IDLE, S_WIN1, S_WIN2, S_DIV0, S_DIV1, S_DIV2, S_DIV3,
      S_MIX0, S_MIX1, S_MIX2, S_MIX3,
      S_DRV1, S_DRV2, S_DRV3, S_DRV4, S_DRV5, S_OUT
   } state_type;

   state_type                                state_ff;
   esl_pkg::esl_cmd_type                     cmd_ff;
   logic [esl_pkg::CSR_W-1:0]                kp_ff, alpha_ff, scale_ff, range_ff;

   logic [COUNT_WIDTH-1:0]                   pos_ff, start_ff;
   logic                                     last_a_ff;
   logic signed [SUM_W-1:0]                  sum_ff, delta_ff;
   logic [esl_pkg::INDEX_W-1:0]              index_ff;
   logic signed [esl_pkg::SPEED_W-1:0]       speed_ff;
   logic signed [esl_pkg::ERROR_W-1:0]       err_ff;
   logic [esl_pkg::DUTY_W-1:0]               duty_ff;
   logic                                     dir_ff;

   logic                                     neg_ff;
   logic [SUM_W-1:0]                         x_ff;
   logic [SUM_W:0]                           q_ff;
   logic signed [esl_pkg::ERROR_W-1:0]       raw_ff;
   logic signed [esl_pkg::PART_W-1:0]        acc_ff, drive_ff;
   logic [esl_pkg::MAG_W-1:0]                mag_ff;
   logic signed [esl_pkg::PROD_W-1:0]        prod_ff;

   logic                                     rsp_valid_ff;
   logic [esl_pkg::DUTY_W-1:0]               rsp_duty_ff;
   logic                                     rsp_dir_ff;
   logic signed [esl_pkg::SPEED_W-1:0]       rsp_speed_ff;
   logic signed [esl_pkg::ERROR_W-1:0]       rsp_err_ff;
   logic signed [esl_pkg::POS_W-1:0]         rsp_pos_ff;

   logic signed [esl_pkg::MUL_A_W-1:0]       mul_a;
   logic signed [esl_pkg::MUL_B_W-1:0]       mul_b;
   logic signed [esl_pkg::MUL_A_W+esl_pkg::MUL_B_W-1:0] mul_p;
   logic signed [esl_pkg::PROD_W-1:0]        prod_in;

   logic [COUNT_WIDTH-1:0]                   diff_in;
   logic signed [DW-1:0]                     dext_in;
   logic signed [SUM_W-1:0]                  delta_in;
   logic signed [SUM_W:0]                    ssum_in;
   logic signed [SUM_W-1:0]                  sum_in;
   logic                                     last_window;
   logic signed [SUM_W:0]                    xneg_in;
   logic [SUM_W:0]                           q0_in;
   logic [31:0]                              qw_in;
   logic [7:0]                               rem_in;
   logic [SUM_W:0]                           q_in;
   logic signed [SUM_W+1:0]                  qs_in, spd_in;
   logic signed [esl_pkg::SPEED_W-1:0]       speed_in;
   logic signed [esl_pkg::MIX_W-1:0]         mix_in;
   logic signed [esl_pkg::MIX_W-17:0]        mixs_in;
   logic signed [esl_pkg::ERROR_W-1:0]       err_in;
   logic signed [esl_pkg::PART_W-1:0]        drive_in;
   logic [esl_pkg::MAG_W-1:0]                dq_in;
   logic [esl_pkg::DUTY_W-1:0]               duty_in;

   assign pop = (state_ff == S_IDLE) && head.valid;

   // shared multiplier: operands chosen by step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_DIV1: begin
            mul_a = $signed(esl_pkg::MUL_A_W'(x_ff));
            mul_b = $signed(esl_pkg::MUL_B_W'(RECIP));
         end
         S_MIX1: begin
            mul_a = esl_pkg::MUL_A_W'(raw_ff);
            mul_b = $signed(esl_pkg::MUL_B_W'(alpha_ff));
         end
         S_MIX2: begin
            mul_a = esl_pkg::MUL_A_W'(err_ff);
            mul_b = $signed(esl_pkg::MUL_B_W'(17'h10000 - 17'(alpha_ff)));
         end
         S_DRV1: begin
            mul_a = esl_pkg::MUL_A_W'(err_ff);
            mul_b = $signed(esl_pkg::MUL_B_W'(kp_ff));
         end
         S_DRV4: begin
            mul_a = $signed(esl_pkg::MUL_A_W'(mag_ff));
            mul_b = $signed(esl_pkg::MUL_B_W'(scale_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p   = mul_a * mul_b;
   assign prod_in = mul_p[esl_pkg::PROD_W-1:0];

   // window delta and sum, both saturated at the sum width
   assign diff_in  = pos_ff - start_ff;
   assign dext_in  = DW'($signed(diff_in));
   assign delta_in = (dext_in > DW'(esl_pkg::SUM_MAX)) ? esl_pkg::SUM_MAX :
                     (dext_in < DW'(esl_pkg::SUM_MIN)) ? esl_pkg::SUM_MIN : SUM_W'(dext_in);
   assign ssum_in  = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(delta_ff);
   assign sum_in   = (ssum_in > (SUM_W+1)'(esl_pkg::SUM_MAX)) ? esl_pkg::SUM_MAX :
                     (ssum_in < (SUM_W+1)'(esl_pkg::SUM_MIN)) ? esl_pkg::SUM_MIN :
                     SUM_W'(ssum_in);
   assign last_window = (7'(index_ff) + 7'd1) >= 7'(WINDOWS_PER_AVERAGE);

   // floor division by the window count through a reciprocal and one fix-up
   assign xneg_in = (SUM_W+1)'(WINDOWS_PER_AVERAGE - 1) - (SUM_W+1)'(sum_ff);
   assign q0_in   = prod_ff[esl_pkg::DIV_SHIFT+SUM_W:esl_pkg::DIV_SHIFT];
   assign qw_in   = 32'(q0_in) * 32'(WINDOWS_PER_AVERAGE);
   assign rem_in  = 8'(32'(x_ff) - qw_in);
   assign q_in    = q0_in + (SUM_W+1)'(rem_in >= 8'(WINDOWS_PER_AVERAGE));
   assign qs_in   = $signed({1'b0, q_ff});
   assign spd_in  = neg_ff ? -qs_in : qs_in;
   assign speed_in = (spd_in > (SUM_W+2)'(esl_pkg::SPEED_MAX)) ? esl_pkg::SPEED_MAX :
                     (spd_in < (SUM_W+2)'(esl_pkg::SPEED_MIN)) ? esl_pkg::SPEED_MIN :
                     esl_pkg::SPEED_W'(spd_in);

   // error filter mix
   assign mix_in  = esl_pkg::MIX_W'(acc_ff) +
                    esl_pkg::MIX_W'($signed(prod_ff[esl_pkg::PART_W-1:0]));
   assign mixs_in = mix_in[esl_pkg::MIX_W-1:16];
   assign err_in  = (mixs_in > (esl_pkg::MIX_W-16)'(esl_pkg::ERR_MAX)) ? esl_pkg::ERR_MAX :
                    (mixs_in < (esl_pkg::MIX_W-16)'(esl_pkg::ERR_MIN)) ? esl_pkg::ERR_MIN :
                    esl_pkg::ERROR_W'(mixs_in);

   // drive stage
   assign drive_in = esl_pkg::PART_W'($signed({cmd_ff.setpoint, 8'b0})) +
                     esl_pkg::PART_W'($signed(prod_ff[esl_pkg::PART_W-1:0]));
   assign dq_in    = prod_ff[esl_pkg::MAG_W+15:16];
   assign duty_in  = (dq_in > esl_pkg::MAG_W'(range_ff)) ? range_ff :
                     dq_in[esl_pkg::DUTY_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         start_ff     <= '0;
         last_a_ff    <= 1'b0;
         sum_ff       <= '0;
         index_ff     <= '0;
         speed_ff     <= '0;
         err_ff       <= '0;
         duty_ff      <= '0;
         dir_ff       <= 1'b0;
      end else begin
         // drop a taken beat; the output step reloads it on its own
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (head.valid) begin
                  cmd_ff <= head.cmd;
                  case (head.cmd.op)
                     esl_pkg::OP_ENC: begin
                        if (head.cmd.enc_a && !last_a_ff) begin
                           pos_ff <= head.cmd.enc_b ? pos_ff + 1'b1 : pos_ff - 1'b1;
                        end
                        last_a_ff <= head.cmd.enc_a;
                        state_ff  <= S_OUT;
                     end
                     esl_pkg::OP_WIN: state_ff <= S_WIN1;
                     esl_pkg::OP_CTL: state_ff <= S_DRV1;
                     default:         state_ff <= S_OUT;
                  endcase
               end
            end
            S_WIN1: begin
               delta_ff <= delta_in;
               start_ff <= pos_ff;
               state_ff <= S_WIN2;
            end
            S_WIN2: begin
               sum_ff <= sum_in;
               if (last_window) begin
                  state_ff <= S_DIV0;
               end else begin
                  index_ff <= index_ff + 1'b1;
                  state_ff <= S_OUT;
               end
            end
            S_DIV0: begin
               neg_ff   <= sum_ff[SUM_W-1];
               x_ff     <= sum_ff[SUM_W-1] ? xneg_in[SUM_W-1:0] : sum_ff[SUM_W-1:0];
               state_ff <= S_DIV1;
            end
            S_DIV1: begin
               prod_ff  <= prod_in;
               state_ff <= S_DIV2;
            end
            S_DIV2: begin
               q_ff     <= q_in;
               state_ff <= S_DIV3;
            end
            S_DIV3: begin
               speed_ff <= speed_in;
               sum_ff   <= '0;
               index_ff <= '0;
               state_ff <= S_MIX0;
            end
            S_MIX0: begin
               raw_ff   <= esl_pkg::ERROR_W'(cmd_ff.setpoint) - esl_pkg::ERROR_W'(speed_ff);
               state_ff <= S_MIX1;
            end
            S_MIX1: begin
               prod_ff  <= prod_in;
               state_ff <= S_MIX2;
            end
            S_MIX2: begin
               acc_ff   <= prod_ff[esl_pkg::PART_W-1:0];
               prod_ff  <= prod_in;
               state_ff <= S_MIX3;
            end
            S_MIX3: begin
               err_ff   <= err_in;
               state_ff <= S_OUT;
            end
            S_DRV1: begin
               prod_ff  <= prod_in;
               state_ff <= S_DRV2;
            end
            S_DRV2: begin
               drive_ff <= drive_in;
               state_ff <= S_DRV3;
            end
            S_DRV3: begin
               mag_ff   <= drive_ff[esl_pkg::PART_W-1] ?
                           esl_pkg::MAG_W'(-drive_ff) : esl_pkg::MAG_W'(drive_ff);
               state_ff <= S_DRV4;
            end
            S_DRV4: begin
               prod_ff  <= prod_in;
               state_ff <= S_DRV5;
            end
            S_DRV5: begin
               duty_ff  <= duty_in;
               dir_ff   <= drive_ff > 0;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_duty_ff  <= duty_ff;
                  rsp_dir_ff   <= dir_ff;
                  rsp_speed_ff <= speed_ff;
                  rsp_err_ff   <= err_ff;
                  rsp_pos_ff   <= esl_pkg::POS_W'($signed(pos_ff));
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff    <= esl_pkg::KP_GAIN_RESET;
         alpha_ff <= esl_pkg::FILTER_ALPHA_RESET;
         scale_ff <= esl_pkg::DUTY_SCALE_RESET;
         range_ff <= esl_pkg::DUTY_RANGE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            esl_pkg::CSR_KP_GAIN:      kp_ff    <= csr_wdata;
            esl_pkg::CSR_FILTER_ALPHA: alpha_ff <= csr_wdata;
            esl_pkg::CSR_DUTY_SCALE:   scale_ff <= csr_wdata;
            esl_pkg::CSR_DUTY_RANGE:   range_ff <= csr_wdata;
            default:                   kp_ff    <= kp_ff;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_duty           = rsp_duty_ff;
   assign rsp_direction      = rsp_dir_ff;
   assign rsp_measured_speed = rsp_speed_ff;
   assign rsp_filtered_error = rsp_err_ff;
   assign rsp_position       = rsp_pos_ff;

   `ESL_ASSERT_NXT(a_pop_leaves_idle, clock, reset, pop, state_ff != S_IDLE)
   `ESL_ASSERT_NXT(a_out_holds, clock, reset, (state_ff == S_OUT) && rsp_valid_ff && rsp_stall, state_ff == S_OUT)
   `ESL_ASSERT_IMP(a_index_range, clock, reset, 1'b1, 7'(index_ff) < 7'(WINDOWS_PER_AVERAGE))
   `ESL_ASSERT_IMP(a_div_fixup, clock, reset, state_ff == S_DIV2, 9'(rem_in) < 9'(2 * WINDOWS_PER_AVERAGE))

endmodule

// ----- hw/rtl/encoder_speed_loop_controller_core.sv -----
// The back sequencer takes one item at a time and finishes it before it takes the next;
// the front takes a beat while its slot is empty or the queue has room.
// Reset (synchronous, active high) zeroes the count, the average, the error and the drive,
// loads the register defaults and empties the queue; no clearing pass is needed.
// ---------------------------------------------------------------------------
// encoder_speed_loop_controller_core
// Speed loop for one motor: quadrature position count, windowed speed
// average, low-pass filtered speed error and proportional drive to duty.
// ---------------------------------------------------------------------------
module encoder_speed_loop_controller_core #(
   parameter int WINDOWS_PER_AVERAGE = 4,
   parameter int COUNT_WIDTH         = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_operation,
   input  logic                                  req_enc_a,
   input  logic                                  req_enc_b,
   input  logic signed [esl_pkg::SETPOINT_W-1:0] req_setpoint,
   // configuration writes
   input  logic                                  csr_we,
   input  logic [esl_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [esl_pkg::CSR_W-1:0]             csr_wdata,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [esl_pkg::DUTY_W-1:0]            rsp_duty,
   output logic                                  rsp_direction,
   output logic signed [esl_pkg::SPEED_W-1:0]    rsp_measured_speed,
   output logic signed [esl_pkg::ERROR_W-1:0]    rsp_filtered_error,
   output logic signed [esl_pkg::POS_W-1:0]      rsp_position
);

   // front to queue and queue to back: valid plus classified command
   esl_pkg::esl_slot_type push;
   esl_pkg::esl_slot_type head;
   logic                  push_ready;
   logic                  pop;

   // Front: register each request beat and classify the operation code.
   esl_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_enc_a     (req_enc_a),
      .req_enc_b     (req_enc_b),
      .req_setpoint  (req_setpoint),
      .push          (push),
      .push_ready    (push_ready)
   );

   // Queue: decouple the front from a busy back; hold up to two commands.
   esl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .head       (head),
      .pop        (pop)
   );

   // Back: run each command through the sequencer and drive the response
   // register, which holds its beat while the sink stalls.
   esl_back #(
      .WINDOWS_PER_AVERAGE (WINDOWS_PER_AVERAGE),
      .COUNT_WIDTH         (COUNT_WIDTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .pop                (pop),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_duty           (rsp_duty),
      .rsp_direction      (rsp_direction),
      .rsp_measured_speed (rsp_measured_speed),
      .rsp_filtered_error (rsp_filtered_error),
      .rsp_position       (rsp_position)
   );

endmodule
